@@ rtl/arcs_pkg.sv @@
// Package for the rotating character sampler: field widths, opcodes,
// register indexes, parameter defaults and the result item type.
// No dependencies.
`timescale 1ns / 1ps

package arcs_pkg;

    localparam int SCREEN_COLS_DEF   = 80;
    localparam int SCREEN_ROWS_DEF   = 22;
    localparam int SOURCE_COLS_DEF   = 64;
    localparam int SOURCE_ROWS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int SROW_W  = 4;
    localparam int SCOL_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 7;
    localparam int SX_W    = 7;
    localparam int SY_W    = 5;
    localparam int TRIG_W  = 18;
    localparam int PIVX_W  = 23;
    localparam int PIVY_W  = 21;
    localparam int COORD_W = 32;
    localparam int PROD_W  = 42;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [OP_W-1:0] OP_CELL  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEN   = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic [1:0] REG_COS  = 2'd0;
    localparam logic [1:0] REG_SIN  = 2'd1;
    localparam logic [1:0] REG_PIVX = 2'd2;
    localparam logic [1:0] REG_PIVY = 2'd3;

    localparam logic [TRIG_W-1:0] COS_RESET  = 18'd65536;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_W      = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic [SX_W-1:0]   screen_x;
        logic [SY_W-1:0]   screen_y;
        logic              row_end;
        logic              frame_end;
    } t_out_item;

endpackage

@@ rtl/arcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read-first). No dependencies.
`timescale 1ns / 1ps

module arcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/affine_rotate_char_sampler.sv @@
// Rotating character sampler: inverse affine map of a stored character image.
// A pixel result passes the s0 and s1 stage registers and the output queue before it is valid.
// Throughput: one item per cycle while the input is not stalled, set by the single cell RAM read per pixel.
// The input stalls after reset and after each register write while the
// frame-offset multipliers settle. A 4-entry output queue absorbs stalls.
// Synchronous active-low reset clears counters, row lengths and the sine and pivot registers, and sets cosine to 1.0.
// Depends on arcs_pkg and arcs_ram.
`timescale 1ns / 1ps

module affine_rotate_char_sampler #(
    parameter int SCREEN_COLS   = arcs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = arcs_pkg::SCREEN_ROWS_DEF,
    parameter int SOURCE_COLS   = arcs_pkg::SOURCE_COLS_DEF,
    parameter int SOURCE_ROWS   = arcs_pkg::SOURCE_ROWS_DEF,
    parameter int FRACTION_BITS = arcs_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [arcs_pkg::OP_W-1:0]       i_opcode,
    input  logic [arcs_pkg::SROW_W-1:0]     i_src_row,
    input  logic [arcs_pkg::SCOL_W-1:0]     i_src_col,
    input  logic [arcs_pkg::CHAR_W-1:0]     i_cell_char,
    input  logic [arcs_pkg::LEN_W-1:0]      i_row_len,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [arcs_pkg::CHAR_W-1:0]     o_pixel_char,
    output logic [arcs_pkg::SX_W-1:0]       o_screen_x,
    output logic [arcs_pkg::SY_W-1:0]       o_screen_y,
    output logic                            o_row_end,
    output logic                            o_frame_end,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arcs_pkg::APB_AW-1:0]     paddr,
    input  logic [arcs_pkg::APB_DW-1:0]     pwdata,
    output logic [arcs_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int ROW_W  = (SOURCE_ROWS > 1) ? $clog2(SOURCE_ROWS) : 1;
    localparam int COL_W  = (SOURCE_COLS > 1) ? $clog2(SOURCE_COLS) : 1;
    localparam int CELLS  = SOURCE_ROWS * SOURCE_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CMP_W  = 10;

    // configuration
    logic signed [arcs_pkg::TRIG_W-1:0] r_cos;
    logic signed [arcs_pkg::TRIG_W-1:0] r_sin;
    logic [arcs_pkg::PIVX_W-1:0]        r_pivot_x;
    logic [arcs_pkg::PIVY_W-1:0]        r_pivot_y;
    logic [arcs_pkg::SETTLE_W-1:0]      r_settle;
    logic                               w_cfg_wr;
    logic [1:0]                         w_cfg_idx;

    // frame offset pipeline
    logic signed [23:0]                 w_px;
    logic signed [23:0]                 w_py;
    logic signed [arcs_pkg::PROD_W-1:0] r_px_c, r_py_s, r_py_c, r_px_s;
    logic signed [arcs_pkg::PROD_W-1:0] w_fl_px_c, w_fl_py_s, w_fl_py_c, w_fl_px_s;
    logic [arcs_pkg::COORD_W-1:0]       r_frame_x, r_frame_y;

    // raster walk
    logic [arcs_pkg::COORD_W-1:0]        w_c32, w_s32;
    logic [arcs_pkg::COORD_W-1:0]        r_line_x, r_line_y, r_walk_x, r_walk_y;
    logic [arcs_pkg::COORD_W-1:0]        w_nline_x, w_nline_y;
    logic signed [arcs_pkg::COORD_W-1:0] w_cur_x, w_cur_y, w_sx, w_sy;
    logic [arcs_pkg::SX_W-1:0]           r_col_cnt;
    logic [arcs_pkg::SY_W-1:0]           r_row_cnt;
    logic                                w_col0, w_frame0, w_last_col, w_last_row;
    logic                                w_inside;

    // handshake
    logic w_in_acc, w_pix_acc, w_out_acc;

    // row lengths
    logic [arcs_pkg::LEN_W-1:0] r_row_len [SOURCE_ROWS];
    logic                       w_len_we;
    logic [ROW_W-1:0]           w_len_widx;

    // cell RAM
    logic              w_cell_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [arcs_pkg::CHAR_W-1:0] w_ram_q;

    // sampling pipeline
    logic                 r_s0_vld, r_s1_vld;
    logic                 r_s0_in, r_s1_hit;
    logic [ROW_W-1:0]     r_s0_row;
    logic [COL_W-1:0]     r_s0_col;
    arcs_pkg::t_out_item  r_s0_meta, r_s1_meta;
    logic [ROW_W-1:0]     w_len_ridx;
    logic [arcs_pkg::LEN_W-1:0] w_len;
    logic                 w_hit;

    // output queue
    arcs_pkg::t_out_item              r_fifo [arcs_pkg::FIFO_DEPTH];
    logic [arcs_pkg::FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [arcs_pkg::FIFO_CNT_W-1:0]  r_fifo_cnt, w_load;
    arcs_pkg::t_out_item              w_push_item, w_head;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[3:2];

    always_comb begin
        case (w_cfg_idx)
            arcs_pkg::REG_COS:  prdata = {{14{r_cos[17]}}, r_cos};
            arcs_pkg::REG_SIN:  prdata = {{14{r_sin[17]}}, r_sin};
            arcs_pkg::REG_PIVX: prdata = {9'd0, r_pivot_x};
            arcs_pkg::REG_PIVY: prdata = {11'd0, r_pivot_y};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos     <= arcs_pkg::COS_RESET;
            r_sin     <= '0;
            r_pivot_x <= '0;
            r_pivot_y <= '0;
            r_settle  <= arcs_pkg::SETTLE_W'(arcs_pkg::SETTLE_CYCLES);
        end else begin
            if (w_cfg_wr) begin
                r_settle <= arcs_pkg::SETTLE_W'(arcs_pkg::SETTLE_CYCLES);
                case (w_cfg_idx)
                    arcs_pkg::REG_COS:  r_cos     <= pwdata[arcs_pkg::TRIG_W-1:0];
                    arcs_pkg::REG_SIN:  r_sin     <= pwdata[arcs_pkg::TRIG_W-1:0];
                    arcs_pkg::REG_PIVX: r_pivot_x <= pwdata[arcs_pkg::PIVX_W-1:0];
                    arcs_pkg::REG_PIVY: r_pivot_y <= pwdata[arcs_pkg::PIVY_W-1:0];
                    default: begin
                    end
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    // ---------------- frame offsets ----------------
    assign w_px = {1'b0, r_pivot_x};
    assign w_py = {3'b0, r_pivot_y};

    always_ff @(posedge i_clk) begin
        r_px_c <= w_px * r_cos;
        r_py_s <= w_py * r_sin;
        r_py_c <= w_py * r_cos;
        r_px_s <= w_px * r_sin;
    end

    assign w_fl_px_c = r_px_c >>> FRACTION_BITS;
    assign w_fl_py_s = r_py_s >>> FRACTION_BITS;
    assign w_fl_py_c = r_py_c >>> FRACTION_BITS;
    assign w_fl_px_s = r_px_s >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        r_frame_x <= {9'd0, r_pivot_x} - w_fl_px_c[arcs_pkg::COORD_W-1:0]
                     + w_fl_py_s[arcs_pkg::COORD_W-1:0];
        r_frame_y <= {11'd0, r_pivot_y} - w_fl_py_c[arcs_pkg::COORD_W-1:0]
                     - w_fl_px_s[arcs_pkg::COORD_W-1:0];
    end

    // ---------------- handshake ----------------
    assign w_load     = r_fifo_cnt + arcs_pkg::FIFO_CNT_W'(r_s0_vld)
                        + arcs_pkg::FIFO_CNT_W'(r_s1_vld);
    assign o_in_stall = (r_settle != '0)
                        || (w_load >= arcs_pkg::FIFO_CNT_W'(arcs_pkg::FIFO_DEPTH));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_pix_acc  = w_in_acc && (i_opcode == arcs_pkg::OP_PIXEL);
    assign w_out_acc  = o_out_valid && !i_out_stall;

    // ---------------- raster walk ----------------
    assign w_c32      = {{14{r_cos[17]}}, r_cos};
    assign w_s32      = {{14{r_sin[17]}}, r_sin};
    assign w_col0     = (r_col_cnt == '0);
    assign w_frame0   = w_col0 && (r_row_cnt == '0);
    assign w_last_col = r_col_cnt >= arcs_pkg::SX_W'(SCREEN_COLS - 1);
    assign w_last_row = r_row_cnt >= arcs_pkg::SY_W'(SCREEN_ROWS - 1);
    assign w_nline_x  = w_frame0 ? r_frame_x : (r_line_x - w_s32);
    assign w_nline_y  = w_frame0 ? r_frame_y : (r_line_y + w_c32);
    assign w_cur_x    = w_col0 ? w_nline_x : r_walk_x;
    assign w_cur_y    = w_col0 ? w_nline_y : r_walk_y;
    assign w_sx       = w_cur_x >>> FRACTION_BITS;
    assign w_sy       = w_cur_y >>> FRACTION_BITS;
    assign w_inside   = !w_sx[arcs_pkg::COORD_W-1]
                        && (w_sx < arcs_pkg::COORD_W'(SOURCE_COLS))
                        && !w_sy[arcs_pkg::COORD_W-1]
                        && (w_sy < arcs_pkg::COORD_W'(SOURCE_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_pix_acc) begin
            if (w_last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_last_row ? '0 : r_row_cnt + 1'b1;
            end else begin
                r_col_cnt <= r_col_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_walk_x <= w_cur_x + w_c32;
            r_walk_y <= w_cur_y + w_s32;
            if (w_col0) begin
                r_line_x <= w_nline_x;
                r_line_y <= w_nline_y;
            end
        end
    end

    // ---------------- row lengths ----------------
    assign w_len_we   = w_in_acc && (i_opcode == arcs_pkg::OP_LEN)
                        && (CMP_W'(i_src_row) < CMP_W'(SOURCE_ROWS));
    assign w_len_widx = ROW_W'(i_src_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SOURCE_ROWS; i++) begin
                r_row_len[i] <= '0;
            end
        end else if (w_len_we) begin
            r_row_len[w_len_widx] <= i_row_len;
        end
    end

    // ---------------- cell RAM ----------------
    assign w_cell_we = w_in_acc && (i_opcode == arcs_pkg::OP_CELL)
                       && (CMP_W'(i_src_row) < CMP_W'(SOURCE_ROWS))
                       && (CMP_W'(i_src_col) < CMP_W'(SOURCE_COLS));
    assign w_waddr   = ADDR_W'(32'(i_src_row) * 32'(SOURCE_COLS) + 32'(i_src_col));
    assign w_raddr   = ADDR_W'(32'(w_len_ridx) * 32'(SOURCE_COLS) + 32'(r_s0_col));

    arcs_ram #(
        .WIDTH(arcs_pkg::CHAR_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (w_cell_we),
        .i_waddr(w_waddr),
        .i_wdata(i_cell_char),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_q)
    );

    // ---------------- sampling pipeline ----------------
    assign w_len_ridx = r_s0_in ? r_s0_row : '0;
    assign w_len      = r_row_len[w_len_ridx];
    assign w_hit      = r_s0_in && (CMP_W'(r_s0_col) < CMP_W'(w_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_pix_acc;
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_in             <= w_inside;
        r_s0_row            <= ROW_W'(w_sy);
        r_s0_col            <= COL_W'(w_sx);
        r_s0_meta.pixel_char <= arcs_pkg::SPACE_CHAR;
        r_s0_meta.screen_x  <= r_col_cnt;
        r_s0_meta.screen_y  <= r_row_cnt;
        r_s0_meta.row_end   <= w_last_col;
        r_s0_meta.frame_end <= w_last_col && w_last_row;
        r_s1_hit            <= w_hit;
        r_s1_meta           <= r_s0_meta;
    end

    always_comb begin
        w_push_item            = r_s1_meta;
        w_push_item.pixel_char = r_s1_hit ? w_ram_q : arcs_pkg::SPACE_CHAR;
    end

    // ---------------- output queue ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s1_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt + arcs_pkg::FIFO_CNT_W'(r_s1_vld)
                          - arcs_pkg::FIFO_CNT_W'(w_out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fifo[r_wr_ptr] <= w_push_item;
        end
    end

    assign w_head       = r_fifo[r_rd_ptr];
    assign o_out_valid  = (r_fifo_cnt != '0);
    assign o_pixel_char = w_head.pixel_char;
    assign o_screen_x   = w_head.screen_x;
    assign o_screen_y   = w_head.screen_y;
    assign o_row_end    = w_head.row_end;
    assign o_frame_end  = w_head.frame_end;

    // ---------------- assertions ----------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= arcs_pkg::FIFO_CNT_W'(arcs_pkg::FIFO_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fifo_cnt == arcs_pkg::FIFO_CNT_W'(arcs_pkg::FIFO_DEPTH)) |-> !r_s1_vld)
        else $error("push into full output queue");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> o_in_stall)
        else $error("item accepted before frame offsets settled");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pix_acc && w_last_col) |=> (r_col_cnt == '0))
        else $error("column counter failed to wrap");

endmodule

@@ dv/pixel_checker.sv @@
`timescale 1ns / 1ps
// Result checker for affine_rotate_char_sampler: mirrors register writes and
// loads, predicts every pixel item and compares the result stream in order.
// Depends on arcs_pkg.

module pixel_checker #(
    parameter int SCREEN_COLS   = arcs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = arcs_pkg::SCREEN_ROWS_DEF,
    parameter int SOURCE_COLS   = arcs_pkg::SOURCE_COLS_DEF,
    parameter int SOURCE_ROWS   = arcs_pkg::SOURCE_ROWS_DEF,
    parameter int FRACTION_BITS = arcs_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [arcs_pkg::OP_W-1:0]   i_opcode,
    input  logic [arcs_pkg::SROW_W-1:0] i_src_row,
    input  logic [arcs_pkg::SCOL_W-1:0] i_src_col,
    input  logic [arcs_pkg::CHAR_W-1:0] i_cell_char,
    input  logic [arcs_pkg::LEN_W-1:0]  i_row_len,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [arcs_pkg::CHAR_W-1:0] i_pixel_char,
    input  logic [arcs_pkg::SX_W-1:0]   i_screen_x,
    input  logic [arcs_pkg::SY_W-1:0]   i_screen_y,
    input  logic                        i_row_end,
    input  logic                        i_frame_end,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [arcs_pkg::APB_AW-1:0] i_paddr,
    input  logic [arcs_pkg::APB_DW-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatches,
    output int                          o_pending
);

    logic [arcs_pkg::CHAR_W-1:0]  cells [SOURCE_ROWS*SOURCE_COLS];
    logic [arcs_pkg::LEN_W-1:0]   lens [SOURCE_ROWS];
    int                           cos_val;
    int                           sin_val;
    logic [arcs_pkg::PIVX_W-1:0]  piv_x;
    logic [arcs_pkg::PIVY_W-1:0]  piv_y;
    logic [arcs_pkg::COORD_W-1:0] line_x;
    logic [arcs_pkg::COORD_W-1:0] line_y;
    logic [arcs_pkg::COORD_W-1:0] walk_x;
    logic [arcs_pkg::COORD_W-1:0] walk_y;
    int                           col_cnt;
    int                           row_cnt;
    arcs_pkg::t_out_item          expected_pixels [$];
    int                           mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic predict_pixel(output arcs_pkg::t_out_item px);
        longint prod_xc;
        longint prod_yc;
        longint prod_xs;
        longint prod_ys;
        int     sx;
        int     sy;
        logic   last_col;
        logic   last_row;
        if (col_cnt == 0) begin
            if (row_cnt == 0) begin
                prod_xc = longint'(piv_x) * longint'(cos_val);
                prod_yc = longint'(piv_y) * longint'(cos_val);
                prod_xs = longint'(piv_x) * longint'(sin_val);
                prod_ys = longint'(piv_y) * longint'(sin_val);
                line_x = arcs_pkg::COORD_W'(piv_x)
                       - arcs_pkg::COORD_W'(prod_xc >>> FRACTION_BITS)
                       + arcs_pkg::COORD_W'(prod_ys >>> FRACTION_BITS);
                line_y = arcs_pkg::COORD_W'(piv_y)
                       - arcs_pkg::COORD_W'(prod_yc >>> FRACTION_BITS)
                       - arcs_pkg::COORD_W'(prod_xs >>> FRACTION_BITS);
            end else begin
                line_x = line_x - arcs_pkg::COORD_W'(sin_val);
                line_y = line_y + arcs_pkg::COORD_W'(cos_val);
            end
            walk_x = line_x;
            walk_y = line_y;
        end
        sx = $signed(walk_x) >>> FRACTION_BITS;
        sy = $signed(walk_y) >>> FRACTION_BITS;
        px.pixel_char = arcs_pkg::SPACE_CHAR;
        if (sx >= 0 && sx < SOURCE_COLS && sy >= 0 && sy < SOURCE_ROWS
                && sx < int'(lens[sy]))
            px.pixel_char = cells[sy*SOURCE_COLS + sx];
        walk_x = walk_x + arcs_pkg::COORD_W'(cos_val);
        walk_y = walk_y + arcs_pkg::COORD_W'(sin_val);
        last_col = (col_cnt >= SCREEN_COLS - 1);
        last_row = (row_cnt >= SCREEN_ROWS - 1);
        px.screen_x  = arcs_pkg::SX_W'(col_cnt);
        px.screen_y  = arcs_pkg::SY_W'(row_cnt);
        px.row_end   = last_col;
        px.frame_end = last_col && last_row;
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    always @(posedge i_clk) begin
        arcs_pkg::t_out_item want;
        if (!i_rst_n) begin
            cos_val = int'($signed(arcs_pkg::COS_RESET));
            sin_val = 0;
            piv_x   = '0;
            piv_y   = '0;
            line_x  = '0;
            line_y  = '0;
            walk_x  = '0;
            walk_y  = '0;
            col_cnt = 0;
            row_cnt = 0;
            foreach (lens[r]) lens[r] = '0;
            expected_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    arcs_pkg::REG_COS:
                        cos_val = int'($signed(i_pwdata[arcs_pkg::TRIG_W-1:0]));
                    arcs_pkg::REG_SIN:
                        sin_val = int'($signed(i_pwdata[arcs_pkg::TRIG_W-1:0]));
                    arcs_pkg::REG_PIVX: piv_x = i_pwdata[arcs_pkg::PIVX_W-1:0];
                    arcs_pkg::REG_PIVY: piv_y = i_pwdata[arcs_pkg::PIVY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_opcode)
                    arcs_pkg::OP_CELL: begin
                        if (i_src_row < SOURCE_ROWS && i_src_col < SOURCE_COLS)
                            cells[i_src_row*SOURCE_COLS + i_src_col] = i_cell_char;
                    end
                    arcs_pkg::OP_LEN: begin
                        if (i_src_row < SOURCE_ROWS)
                            lens[i_src_row] = i_row_len;
                    end
                    arcs_pkg::OP_PIXEL: begin
                        predict_pixel(want);
                        expected_pixels.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected item at (%0d,%0d)",
                                              i_screen_x, i_screen_y));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_char !== want.pixel_char)
                        report_mismatch($sformatf("pixel_char %h, want %h at (%0d,%0d)",
                            i_pixel_char, want.pixel_char, want.screen_x, want.screen_y));
                    if (i_screen_x !== want.screen_x)
                        report_mismatch($sformatf("screen_x %0d, want %0d",
                            i_screen_x, want.screen_x));
                    if (i_screen_y !== want.screen_y)
                        report_mismatch($sformatf("screen_y %0d, want %0d",
                            i_screen_y, want.screen_y));
                    if (i_row_end !== want.row_end)
                        report_mismatch($sformatf("row_end %b, want %b at (%0d,%0d)",
                            i_row_end, want.row_end, want.screen_x, want.screen_y));
                    if (i_frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, want %b at (%0d,%0d)",
                            i_frame_end, want.frame_end, want.screen_x, want.screen_y));
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the rotating character sampler testbench: clock, reset, register
// writes, load and pixel stimulus over idling phases, and the verdict.
// Depends on arcs_pkg, affine_rotate_char_sampler and pixel_checker.

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int SRC_ROWS     = arcs_pkg::SOURCE_ROWS_DEF;
    localparam int SRC_COLS     = arcs_pkg::SOURCE_COLS_DEF;
    localparam int FRAC_ONE     = 1 << arcs_pkg::FRACTION_BITS_DEF;
    localparam int PIVX_MAX     = SRC_COLS * FRAC_ONE;
    localparam int PIVY_MAX     = SRC_ROWS * FRAC_ONE;
    localparam int LEN_MAX      = (1 << arcs_pkg::LEN_W) - 1;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [arcs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic [arcs_pkg::OP_W-1:0]    i_opcode    = '0;
    logic [arcs_pkg::SROW_W-1:0]  i_src_row   = '0;
    logic [arcs_pkg::SCOL_W-1:0]  i_src_col   = '0;
    logic [arcs_pkg::CHAR_W-1:0]  i_cell_char = '0;
    logic [arcs_pkg::LEN_W-1:0]   i_row_len   = '0;
    logic                         i_out_stall = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [arcs_pkg::APB_AW-1:0]  paddr       = '0;
    logic [arcs_pkg::APB_DW-1:0]  pwdata      = '0;

    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [arcs_pkg::CHAR_W-1:0]  o_pixel_char;
    logic [arcs_pkg::SX_W-1:0]    o_screen_x;
    logic [arcs_pkg::SY_W-1:0]    o_screen_y;
    logic                         o_row_end;
    logic                         o_frame_end;
    logic [arcs_pkg::APB_DW-1:0]  prdata;
    logic                         pready;

    int mismatch_total;
    int pending_pixels;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int item_count     = 0;
    int cycle_count    = 0;
    bit hold_req       = 1'b0;
    bit hold_off       = 1'b0;
    bit cell_written [SRC_ROWS][SRC_COLS];
    int filled [SRC_ROWS];

    affine_rotate_char_sampler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_src_row    (i_src_row),
        .i_src_col    (i_src_col),
        .i_cell_char  (i_cell_char),
        .i_row_len    (i_row_len),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_char (o_pixel_char),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pixel_checker u_pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_src_row    (i_src_row),
        .i_src_col    (i_src_col),
        .i_cell_char  (i_cell_char),
        .i_row_len    (i_row_len),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_pixel_char (o_pixel_char),
        .i_screen_x   (o_screen_x),
        .i_screen_y   (o_screen_y),
        .i_row_end    (o_row_end),
        .i_frame_end  (o_frame_end),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatch_total),
        .o_pending    (pending_pixels)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // hold the result side off for a long stretch so the block backs up
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int cos_v, input int sin_v, input int px, input int py);
        write_reg(arcs_pkg::REG_COS, cos_v);
        write_reg(arcs_pkg::REG_SIN, sin_v);
        write_reg(arcs_pkg::REG_PIVX, px);
        write_reg(arcs_pkg::REG_PIVY, py);
    endtask

    task automatic send_item(input logic [arcs_pkg::OP_W-1:0] op,
                             input logic [arcs_pkg::SROW_W-1:0] row,
                             input logic [arcs_pkg::SCOL_W-1:0] col,
                             input logic [arcs_pkg::CHAR_W-1:0] ch,
                             input logic [arcs_pkg::LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_opcode    <= op;
        i_src_row   <= row;
        i_src_col   <= col;
        i_cell_char <= ch;
        i_row_len   <= len;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op != OP_UNUSED)
            item_count++;
    endtask

    task automatic emit_pixel();
        send_item(arcs_pkg::OP_PIXEL, arcs_pkg::SROW_W'($urandom),
                  arcs_pkg::SCOL_W'($urandom), arcs_pkg::CHAR_W'($urandom),
                  arcs_pkg::LEN_W'($urandom));
    endtask

    task automatic load_cell(input int row, input int col,
                             input logic [arcs_pkg::CHAR_W-1:0] ch);
        send_item(arcs_pkg::OP_CELL, arcs_pkg::SROW_W'(row), arcs_pkg::SCOL_W'(col), ch,
                  arcs_pkg::LEN_W'($urandom));
        cell_written[row][col] = 1'b1;
        while (filled[row] < SRC_COLS && cell_written[row][filled[row]])
            filled[row]++;
    endtask

    // length never reaches past the written prefix of the row unless the whole row is written
    task automatic load_length(input int row);
        int len;
        len = (filled[row] == SRC_COLS) ? $urandom_range(LEN_MAX) : $urandom_range(filled[row]);
        send_item(arcs_pkg::OP_LEN, arcs_pkg::SROW_W'(row), arcs_pkg::SCOL_W'($urandom),
                  arcs_pkg::CHAR_W'($urandom), arcs_pkg::LEN_W'(len));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int roll;
        int row;
        int run;
        int phase_start;
        foreach (filled[r]) filled[r] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(FRAC_ONE, 0, 0, 0);

        load_cell(0, 0, 8'h00);
        load_cell(0, 1, 8'hFF);
        load_cell(SRC_ROWS - 1, SRC_COLS - 1, 8'h5A);
        send_item(arcs_pkg::OP_LEN, 4'd0, 6'd0, 8'h00, 7'd2);
        send_item(arcs_pkg::OP_LEN, 4'hF, 6'h3F, 8'hFF, 7'd0);
        send_item(OP_UNUSED, 4'hF, 6'h3F, 8'hFF, 7'h7F);
        send_item(OP_UNUSED, 4'h0, 6'h00, 8'h00, 7'h00);
        repeat (5) emit_pixel();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: configure(FRAC_ONE, 0, PIVX_MAX, PIVY_MAX);
                1: configure(-FRAC_ONE, 0, PIVX_MAX, PIVY_MAX);
                2: configure(0, FRAC_ONE, 32 * FRAC_ONE, 8 * FRAC_ONE);
                3: configure(0, -FRAC_ONE, 0, 0);
                4: configure(46341, -46341, 32 * FRAC_ONE + $urandom_range(FRAC_ONE - 1),
                             8 * FRAC_ONE + $urandom_range(FRAC_ONE - 1));
                default: configure(int'($urandom_range(2 * FRAC_ONE)) - FRAC_ONE,
                                   int'($urandom_range(2 * FRAC_ONE)) - FRAC_ONE,
                                   $urandom_range(PIVX_MAX), $urandom_range(PIVY_MAX));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            phase_start = item_count;
            while (item_count - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 18) begin
                    // fill a row in column order, then publish its length
                    row = $urandom_range(SRC_ROWS - 1);
                    run = ($urandom_range(3) == 0) ? SRC_COLS : $urandom_range(16, 1);
                    for (int k = 0; k < run && filled[row] < SRC_COLS; k++)
                        load_cell(row, filled[row], arcs_pkg::CHAR_W'($urandom));
                    load_length(row);
                end else if (roll < 24) begin
                    case ($urandom_range(2))
                        0: load_cell($urandom_range(SRC_ROWS - 1), $urandom_range(SRC_COLS - 1),
                                     arcs_pkg::CHAR_W'($urandom));
                        1: load_length($urandom_range(SRC_ROWS - 1));
                        default: send_item(OP_UNUSED, arcs_pkg::SROW_W'($urandom),
                                           arcs_pkg::SCOL_W'($urandom),
                                           arcs_pkg::CHAR_W'($urandom),
                                           arcs_pkg::LEN_W'($urandom));
                    endcase
                end else begin
                    repeat ($urandom_range(120, 1)) emit_pixel();
                end
            end
        end

        drain();
        if (mismatch_total == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
